// File: design/assert_macros.svh
// Assertion macros for the checker file fma_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion clocked on i_clk, disabled during reset.
`define CHECK_PROP(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Concurrent assertion clocked on i_clk, active during reset as well.
`define CHECK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`endif

// File: design/fma_pkg.sv
// Package with types and constants of the float32 magnitude adder.
package fma_pkg;
    localparam int FRAC_BITS = 23;
    localparam int EXP_BITS  = 8;
    localparam int SIG_BITS  = FRAC_BITS + 1;
    localparam int DEPTH     = 3;

    typedef struct packed {
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } t_req;

    typedef struct packed {
        logic [31:0] sum_word;
        logic        exponent_wrapped;
    } t_res;

    // Stage 1 to stage 2: operands ordered, shift distance known.
    typedef struct packed {
        logic                sign;
        logic [EXP_BITS-1:0] exp_big;
        logic [SIG_BITS-1:0] sig_big;
        logic [SIG_BITS-1:0] sig_small;
        logic [EXP_BITS-1:0] shift_dist;
    } t_align;

    // Stage 2 to stage 3: raw sum.
    typedef struct packed {
        logic                sign;
        logic [EXP_BITS-1:0] exp_big;
        logic [SIG_BITS:0]   total;
    } t_sum;
endpackage

// File: design/fma_align.sv
// Stage 1: unpack operands, pick the larger exponent and the shift distance.
module fma_align import fma_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_req   i_req,
    output logic   o_valid,
    output t_align o_align
);
    logic [EXP_BITS-1:0] exp_a, exp_b;
    logic [SIG_BITS-1:0] sig_a, sig_b;
    logic                r_valid;
    t_align              r_align, n_align;

    always_comb begin
        exp_a = i_req.operand_a[30:23];
        exp_b = i_req.operand_b[30:23];
        sig_a = {1'b1, i_req.operand_a[FRAC_BITS-1:0]};
        sig_b = {1'b1, i_req.operand_b[FRAC_BITS-1:0]};
        n_align.sign = i_req.operand_a[31];
        if (exp_a < exp_b) begin
            n_align.exp_big    = exp_b;
            n_align.sig_big    = sig_b;
            n_align.sig_small  = sig_a;
            n_align.shift_dist = exp_b - exp_a;
        end else begin
            n_align.exp_big    = exp_a;
            n_align.sig_big    = sig_a;
            n_align.sig_small  = sig_b;
            n_align.shift_dist = exp_a - exp_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_align <= n_align;
    end

    assign o_valid = r_valid;
    assign o_align = r_align;
endmodule

// File: design/fma_shift_add.sv
// Stage 2: align the smaller significand and add.
module fma_shift_add import fma_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_align i_align,
    output logic   o_valid,
    output t_sum   o_sum
);
    logic [SIG_BITS-1:0] shifted;
    logic                r_valid;
    t_sum                r_sum, n_sum;

    always_comb begin
        if (i_align.shift_dist >= EXP_BITS'(SIG_BITS)) begin
            shifted = '0;
        end else begin
            shifted = i_align.sig_small >> i_align.shift_dist;
        end
        n_sum.sign    = i_align.sign;
        n_sum.exp_big = i_align.exp_big;
        n_sum.total   = {1'b0, i_align.sig_big} + {1'b0, shifted};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_sum <= n_sum;
    end

    assign o_valid = r_valid;
    assign o_sum   = r_sum;
endmodule

// File: design/fma_normalize.sv
// Stage 3: one-bit normalize on carry and pack the result word.
module fma_normalize import fma_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sum i_sum,
    output logic o_valid,
    output t_res o_res
);
    logic [EXP_BITS:0]    exp_inc;
    logic [FRAC_BITS-1:0] frac;
    logic                 r_valid;
    t_res                 r_res, n_res;

    always_comb begin
        exp_inc = {1'b0, i_sum.exp_big} + (EXP_BITS+1)'(i_sum.total[SIG_BITS]);
        if (i_sum.total[SIG_BITS]) begin
            frac = i_sum.total[FRAC_BITS:1];
        end else begin
            frac = i_sum.total[FRAC_BITS-1:0];
        end
        n_res.sum_word         = {i_sum.sign, exp_inc[EXP_BITS-1:0], frac};
        n_res.exponent_wrapped = exp_inc[EXP_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

// File: design/float32_magnitude_adder_unit.sv
// Top level of the float32 magnitude adder.
// Adds the magnitudes of two single-precision words, always with an implicit
// leading one, truncating alignment and a one-bit normalize; the result takes
// operand_a's sign and o_res.exponent_wrapped flags an exponent wrap past 255.
// A request is taken on any cycle with start high; busy is always low, so one
// request per cycle is accepted. Each result appears for one cycle with o_done
// high after it has passed the three register stages (align, shift and add,
// normalize) in turn. The receiver cannot stall the results.
module float32_magnitude_adder_unit import fma_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_res o_res
);
    logic   v1, v2;
    t_align align1;
    t_sum   sum2;

    assign busy = 1'b0;

    fma_align u_align (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start), .i_req(i_req),
        .o_valid(v1), .o_align(align1)
    );

    fma_shift_add u_shift_add (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v1), .i_align(align1),
        .o_valid(v2), .o_sum(sum2)
    );

    fma_normalize u_normalize (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v2), .i_sum(sum2),
        .o_valid(o_done), .o_res(o_res)
    );
endmodule

// File: design/fma_checker.sv
// Port-level checker for the float32 magnitude adder, bound to the top level.
`include "assert_macros.svh"
module fma_checker import fma_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_req i_req,
    input logic o_done,
    input t_res o_res
);
    `CHECK_PROP(a_latency, (start && !busy) |-> ##DEPTH o_done, "request produced no result")
    `CHECK_PROP(a_no_spurious, o_done |-> $past(start && !busy, DEPTH), "result without request")
    `CHECK_PROP(a_sign, o_done |-> (o_res.sum_word[31] == $past(i_req.operand_a[31], DEPTH)), "sign")
    `CHECK_PROP(a_wrap_exp, o_res.exponent_wrapped && o_done |-> (o_res.sum_word[30:23] == 8'd0), "wrap")
    `CHECK_ALWAYS(a_reset_idle, !i_rst_n |=> !o_done, "result right after reset")
endmodule

bind float32_magnitude_adder_unit fma_checker u_fma_checker (.*);
